>>> hdl/plst_pkg.sv
// plst_pkg: shared types and codes for the positional insert/delete list
// used by plst_cell and positional_insert_delete_list_top; no dependencies
package plst_pkg;

    localparam int CNT_W  = 7;
    localparam int DATA_W = 32;

    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [DATA_W-1:0] data_t;

    // operation kinds on the input word
    localparam logic [1:0] KIND_INSERT   = 2'd0;
    localparam logic [1:0] KIND_DELETE   = 2'd1;
    localparam logic [1:0] KIND_TRAVERSE = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    // broadcast operation to the cell row
    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_INS  = 2'd1;
    localparam logic [1:0] CELL_DEL  = 2'd2;
    localparam logic [1:0] CELL_ROT  = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        cnt_t       pos;
        cnt_t       last_idx;
    } cell_ctrl_t;

endpackage

>>> hdl/positional_insert_delete_list_top.sv
// positional_insert_delete_list_top: ordered list held in a row of plst_cell entries
// depends on plst_pkg and plst_cell
//
//   channel | handshake           | fields
//   input   | in_valid / in_ready | kind, position, value
//   output  | out_valid/out_ready | status, element, last
//
// insert and delete shift all entries at once; unused kinds are taken and dropped
// traverse: the accepting cycle starts the walk, then each cycle the output slot is free
// the row rotates by one place and cell zero is sent, leaving the list as it was
// one output register; a stalled output holds the list and blocks new words
// reset clears the count and control; entry contents are undefined until written
module positional_insert_delete_list_top #(
    parameter int DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         kind,
    input  plst_pkg::cnt_t     position,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic signed [31:0] element,
    output logic               last
);
    import plst_pkg::*;

    localparam cnt_t DEPTH_V = CNT_W'(DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_TRAV = 1'b1;

    logic       state_reg, state_next;
    cnt_t       cnt_reg, cnt_next;
    cnt_t       idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [1:0] status_reg, status_next;
    data_t      element_reg, element_next;
    logic       last_reg, last_next;

    cell_ctrl_t ctrl;
    data_t      cell_q [DEPTH];

    logic slot_free;
    logic in_acc;
    logic trav_load;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && slot_free;
    assign in_acc    = in_valid && in_ready;
    assign trav_load = (state_reg == S_TRAV) && slot_free;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        element_next   = element_reg;
        last_next      = last_reg;
        ctrl.op        = CELL_HOLD;
        ctrl.pos       = position;
        ctrl.last_idx  = cnt_reg - CNT_W'(1);

        if (in_acc)
        begin
            element_next = '0;
            last_next    = 1'b1;
            case (kind)
                KIND_INSERT:
                begin
                    out_valid_next = 1'b1;
                    if (cnt_reg >= DEPTH_V)
                        status_next = ST_FULL;
                    else if (position > cnt_reg)
                        status_next = ST_BADPOS;
                    else
                    begin
                        status_next = ST_OK;
                        ctrl.op     = CELL_INS;
                        cnt_next    = cnt_reg + CNT_W'(1);
                    end
                end
                KIND_DELETE:
                begin
                    out_valid_next = 1'b1;
                    if (position >= cnt_reg)
                        status_next = ST_BADPOS;
                    else
                    begin
                        status_next = ST_OK;
                        ctrl.op     = CELL_DEL;
                        cnt_next    = cnt_reg - CNT_W'(1);
                    end
                end
                KIND_TRAVERSE:
                begin
                    if (cnt_reg == '0)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ST_EMPTY;
                    end
                    else
                    begin
                        state_next = S_TRAV;
                        idx_next   = '0;
                    end
                end
                default:
                begin
                    // unused kind: word taken, nothing produced
                end
            endcase
        end
        else if (trav_load)
        begin
            ctrl.op        = CELL_ROT;
            out_valid_next = 1'b1;
            status_next    = ST_OK;
            element_next   = cell_q[0];
            last_next      = (idx_reg == ctrl.last_idx);
            idx_next       = idx_reg + CNT_W'(1);
            if (idx_reg == ctrl.last_idx)
                state_next = S_IDLE;
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        plst_cell #(
            .IDX (g)
        ) u_cell (
            .clk   (clk),
            .ctrl  (ctrl),
            .value (value),
            .left  (cell_q[(g == 0) ? 0 : g - 1]),
            .right (cell_q[(g == DEPTH - 1) ? g : g + 1]),
            .head  (cell_q[0]),
            .data  (cell_q[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        element_reg <= element_next;
        last_reg    <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign element   = element_reg;
    assign last      = last_reg;

    // count stays within the row
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH_V)
        else $error("entry count beyond depth");

    // a traverse only runs over a non-empty list
    a_trav_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TRAV |-> cnt_reg != '0)
        else $error("traverse with empty list");

    // non-empty traverse enters the walk and produces no word yet
    a_trav_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && kind == KIND_TRAVERSE && cnt_reg != '0
        |=> state_reg == S_TRAV && idx_reg == '0)
        else $error("traverse did not start");

    // the final entry of a walk is marked last and ends the walk
    a_trav_end: assert property (@(posedge clk) disable iff (!rst_n)
        trav_load && idx_reg == ctrl.last_idx
        |=> state_reg == S_IDLE && out_valid_reg && last_reg)
        else $error("traverse end not marked");

    // count moves only on an accepted word
    a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_acc |=> $stable(cnt_reg))
        else $error("count changed without a word");

endmodule

>>> hdl/plst_cell.sv
// plst_cell: one list entry, shifts with its neighbours on insert, delete and rotate
// depends on plst_pkg
module plst_cell #(
    parameter int IDX = 0
) (
    input  logic               clk,
    input  plst_pkg::cell_ctrl_t ctrl,
    input  plst_pkg::data_t    value,
    input  plst_pkg::data_t    left,
    input  plst_pkg::data_t    right,
    input  plst_pkg::data_t    head,
    output plst_pkg::data_t    data
);
    import plst_pkg::*;

    localparam cnt_t IDX_V = CNT_W'(IDX);

    data_t data_reg;
    data_t data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_INS:
            begin
                if (IDX_V == ctrl.pos)
                    data_next = value;
                else if (IDX_V > ctrl.pos)
                    data_next = left;
            end
            CELL_DEL:
            begin
                if (IDX_V >= ctrl.pos)
                    data_next = right;
            end
            CELL_ROT:
            begin
                // rotate the used part of the row by one towards cell zero
                if (IDX_V < ctrl.last_idx)
                    data_next = right;
                else if (IDX_V == ctrl.last_idx)
                    data_next = head;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

>>> dv/tb_positional_insert_delete_list_top.sv
`timescale 1ns / 100ps
// tb_positional_insert_delete_list_top: self-checking bench for the positional insert/delete list
// depends on plst_pkg and positional_insert_delete_list_top; keeps its own list and predicts
// every result word, with directed words first and then random runs that fill and drain the list
module tb_positional_insert_delete_list_top;

    import plst_pkg::*;

    localparam int          LIST_DEPTH   = 64;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 50;
    localparam logic [1:0]  KIND_UNUSED  = 2'd3;

    localparam int RUN_FILL  = 0;
    localparam int RUN_DRAIN = 1;
    localparam int RUN_MIXED = 2;

    typedef enum logic [2:0] {
        PH_STEADY,
        PH_SENDER_GAPS,
        PH_SINK_STALLS,
        PH_BOTH_IDLE,
        PH_BACKPRESSURE
    } phase_t;

    typedef struct packed {
        logic [1:0] op;
        cnt_t       pos;
        data_t      val;
    } list_word_t;

    typedef struct packed {
        logic [1:0] status;
        data_t      element;
        logic       last;
    } list_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         kind = KIND_INSERT;
    cnt_t               position = '0;
    logic signed [31:0] value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         status;
    logic signed [31:0] element;
    logic               last;

    phase_t             phase = PH_STEADY;
    list_word_t         pending_words[$];
    list_result_t       expected_results[$];
    data_t              list_model[$];
    int                 gen_count = 0;
    int                 fail_count = 0;
    int                 cycle_count = 0;
    int                 hold_left = 0;
    logic               hold_started = 1'b0;
    list_result_t       want;

    positional_insert_delete_list_top #(
        .DEPTH(LIST_DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .position (position),
        .value    (value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status   (status),
        .element  (element),
        .last     (last)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_positional_insert_delete_list_top: FAIL");
            $finish;
        end
    end

    // expected results of one accepted word, and the list update it makes
    task automatic predict_list_op(input logic [1:0] op, input cnt_t pos, input data_t val);
        list_result_t r;
        r.status  = ST_OK;
        r.element = '0;
        r.last    = 1'b1;
        case (op)
            KIND_INSERT:
            begin
                if (list_model.size() >= LIST_DEPTH)
                    r.status = ST_FULL;
                else if (int'(pos) > list_model.size())
                    r.status = ST_BADPOS;
                else if (int'(pos) == list_model.size())
                    list_model.push_back(val);
                else
                    list_model.insert(int'(pos), val);
                expected_results.push_back(r);
            end
            KIND_DELETE:
            begin
                if (int'(pos) >= list_model.size())
                    r.status = ST_BADPOS;
                else
                    list_model.delete(int'(pos));
                expected_results.push_back(r);
            end
            KIND_TRAVERSE:
            begin
                if (list_model.size() == 0)
                begin
                    r.status = ST_EMPTY;
                    expected_results.push_back(r);
                end
                else
                begin
                    foreach (list_model[i])
                    begin
                        r.element = list_model[i];
                        r.last    = (i == list_model.size() - 1);
                        expected_results.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // driver: holds a word until accepted, then offers the next one unless idling
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            kind     <= KIND_INSERT;
            position <= '0;
            value    <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_list_op(kind, position, value);
            if (!in_valid || in_ready)
            begin
                if (pending_words.size() != 0 &&
                    !((phase == PH_SENDER_GAPS && $urandom_range(0, 99) < 70) ||
                      (phase == PH_BOTH_IDLE && $urandom_range(0, 99) < 25)))
                begin
                    kind     <= pending_words[0].op;
                    position <= pending_words[0].pos;
                    value    <= pending_words[0].val;
                    void'(pending_words.pop_front());
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // one long hold-off so the output backs up into the input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_started <= 1'b0;
            hold_left    <= 0;
        end
        else if (phase == PH_BACKPRESSURE && !hold_started)
        begin
            hold_started <= 1'b1;
            hold_left    <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // monitor: checks each result word against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with nothing expected: status=%0d element=%0d last=%0d",
                             $time, status, element, last);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                    begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, status);
                        fail_count++;
                    end
                    if (element !== want.element)
                    begin
                        $display("%0t: element mismatch: expected %0d, actual %0d",
                                 $time, $signed(want.element), element);
                        fail_count++;
                    end
                    if (last !== want.last)
                    begin
                        $display("%0t: last mismatch: expected %0d, actual %0d",
                                 $time, want.last, last);
                        fail_count++;
                    end
                end
            end
            if (hold_left != 0)
                out_ready <= 1'b0;
            else if (phase == PH_SINK_STALLS)
                out_ready <= ($urandom_range(0, 99) >= 70);
            else if (phase == PH_BOTH_IDLE)
                out_ready <= ($urandom_range(0, 99) >= 25);
            else
                out_ready <= 1'b1;
        end
    end

    // stimulus side keeps only the count, so it can aim positions at valid slots
    task automatic queue_word(input logic [1:0] op, input int pos, input data_t val);
        list_word_t w;
        w.op  = op;
        w.pos = cnt_t'(pos);
        w.val = val;
        pending_words.push_back(w);
        if (op == KIND_INSERT && gen_count < LIST_DEPTH && pos <= gen_count)
            gen_count++;
        else if (op == KIND_DELETE && pos < gen_count)
            gen_count--;
    endtask

    function automatic data_t rand_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_run(input int mode, input int len);
        int roll;
        int ins_pct;
        ins_pct = (mode == RUN_FILL) ? 82 : (mode == RUN_DRAIN) ? 24 : 50;
        for (int i = 0; i < len; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 6)
                queue_word(KIND_TRAVERSE, $urandom_range(0, 127), rand_value());
            else if (roll < 12)
                queue_word(2'($urandom_range(0, 3)), $urandom_range(0, 127), rand_value());
            else if (roll < 12 + ins_pct)
                queue_word(KIND_INSERT, $urandom_range(0, gen_count), rand_value());
            else if (gen_count != 0)
                queue_word(KIND_DELETE, $urandom_range(0, gen_count - 1), rand_value());
            else
                queue_word(KIND_DELETE, $urandom_range(0, 3), rand_value());
        end
    endtask

    task automatic queue_mixed(input int total);
        int len;
        int done;
        done = 0;
        while (done < total)
        begin
            len = $urandom_range(8, 40);
            queue_run($urandom_range(RUN_FILL, RUN_MIXED), len);
            done += len;
        end
    endtask

    task automatic wait_words_taken();
        while (pending_words.size() != 0 || in_valid)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty list cases, ends of the list and field extremes
        phase = PH_STEADY;
        queue_word(KIND_TRAVERSE, 0, 32'h0);
        queue_word(KIND_DELETE, 0, 32'hffff_ffff);
        queue_word(KIND_INSERT, 1, 32'h1234_5678);
        queue_word(KIND_INSERT, 127, 32'hffff_ffff);
        queue_word(KIND_UNUSED, 127, 32'hffff_ffff);
        queue_word(KIND_INSERT, 0, 32'h8000_0000);
        queue_word(KIND_INSERT, 1, 32'h7fff_ffff);
        queue_word(KIND_INSERT, 0, 32'hffff_ffff);
        queue_word(KIND_INSERT, 1, 32'h0000_0000);
        queue_word(KIND_INSERT, 2, 32'h5555_5555);
        queue_word(KIND_INSERT, 5, 32'haaaa_aaaa);
        queue_word(KIND_TRAVERSE, 127, 32'hffff_ffff);
        queue_word(KIND_DELETE, 6, 32'h0);
        queue_word(KIND_DELETE, 127, 32'h0);
        queue_word(KIND_DELETE, 2, 32'h0);
        queue_word(KIND_DELETE, 0, 32'h0);
        queue_word(KIND_DELETE, gen_count - 1, 32'h0);
        queue_word(KIND_UNUSED, 0, 32'h0);
        queue_word(KIND_TRAVERSE, 0, 32'h0);

        // fill to the top, then push against a full list
        while (gen_count < LIST_DEPTH)
            queue_word(KIND_INSERT, $urandom_range(0, gen_count), rand_value());
        queue_word(KIND_INSERT, LIST_DEPTH, rand_value());
        queue_word(KIND_INSERT, 0, rand_value());
        queue_word(KIND_INSERT, 127, rand_value());
        queue_word(KIND_TRAVERSE, 0, 32'h0);
        queue_word(KIND_DELETE, LIST_DEPTH, 32'h0);
        queue_word(KIND_DELETE, LIST_DEPTH - 1, 32'h0);
        queue_mixed(20);
        wait_words_taken();

        phase = PH_SENDER_GAPS;
        queue_mixed(75);
        wait_words_taken();

        phase = PH_SINK_STALLS;
        queue_mixed(75);
        wait_words_taken();

        phase = PH_BOTH_IDLE;
        queue_mixed(75);
        wait_words_taken();

        phase = PH_BACKPRESSURE;
        queue_run(RUN_MIXED, 60);
        wait_words_taken();

        // finish with a drain to empty and a look at the empty list
        phase = PH_STEADY;
        while (gen_count != 0)
            queue_word(KIND_DELETE, $urandom_range(0, gen_count - 1), rand_value());
        queue_word(KIND_TRAVERSE, 0, 32'h0);
        queue_word(KIND_DELETE, 0, 32'h0);
        wait_words_taken();

        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("tb_positional_insert_delete_list_top: PASS");
        else
            $display("tb_positional_insert_delete_list_top: FAIL");
        $finish;
    end

endmodule
